### hdl/bdqs_pkg.sv
package bdqs_pkg;

    // Default sizes of the store.
    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    // Fixed widths of the beat fields.
    localparam int CMD_W    = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // Command codes; code 7 is unused and leaves the list unchanged.
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_FRONT = 3'd0,
        CMD_ADD_BACK  = 3'd1,
        CMD_RM_FRONT  = 3'd2,
        CMD_RM_BACK   = 3'd3,
        CMD_RM_VALUE  = 3'd4,
        CMD_SEARCH    = 3'd5,
        CMD_CLEAR     = 3'd6
    } cmd_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Status flags that travel with every result.
    typedef struct packed {
        status_t status;
        logic    found;
    } flags_t;

endpackage

### hdl/bdqs_ram.sv
module bdqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one read port with registered data.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/bdqs_ctrl.sv
module bdqs_ctrl #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Command side
    input  logic                                in_valid,
    output logic                                in_ready,
    input  bdqs_pkg::cmd_t                      in_cmd,
    input  logic [bdqs_pkg::DATA_W-1:0]         in_value,
    // Result side
    output logic                                res_valid,
    input  logic                                res_ready,
    output bdqs_pkg::flags_t                    res_flags,
    output logic [$clog2(CAPACITY+1)-1:0]       res_count,
    output logic                                res_empty,
    output logic [bdqs_pkg::DATA_W-1:0]         res_front,
    output logic [bdqs_pkg::DATA_W-1:0]         res_back,
    // Store port
    output logic                                ram_we,
    output logic [$clog2(CAPACITY)-1:0]         ram_waddr,
    output logic [VALUE_WIDTH-1:0]              ram_wdata,
    output logic [$clog2(CAPACITY)-1:0]         ram_raddr,
    input  logic [VALUE_WIDTH-1:0]              ram_rdata
);
    import bdqs_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FETCH_F,
        S_FETCH_B,
        S_FIN
    } state_t;

    state_t            state_reg;
    cmd_t              cmd_reg;
    logic [VALUE_WIDTH-1:0] key_reg;
    logic [AW-1:0]     head_reg;
    logic [CW-1:0]     count_reg;
    status_t           status_reg;
    logic              found_reg;
    logic [CW-1:0]     rd_pos_reg;
    logic              cmp_valid_reg;
    logic [CW-1:0]     cmp_pos_reg;
    logic              wr_valid_reg;
    logic [CW-1:0]     wr_pos_reg;
    logic [VALUE_WIDTH-1:0] front_reg;

    // Physical slot of a list position, wrapped around the circular store.
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] pos);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(pos);
        if (sum >= (CW+1)'(CAPACITY)) begin
            sum = sum - (CW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    logic [63:0]            in_wide;
    logic [VALUE_WIDTH-1:0] in_key;
    logic                   full;
    logic                   empty;
    logic [AW-1:0]          head_m1;
    logic [AW-1:0]          head_p1;
    logic [CW-1:0]          back_pos;
    logic                   hit;
    logic [63:0]            front_wide;
    logic [63:0]            back_wide;

    // Kept value: the low bits of the incoming value.
    assign in_wide = 64'(in_value);
    assign in_key  = in_wide[VALUE_WIDTH-1:0];

    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign head_m1  = (head_reg == '0) ? AW'(CAPACITY - 1) : head_reg - 1'b1;
    assign head_p1  = (head_reg == AW'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;
    assign back_pos = empty ? '0 : count_reg - 1'b1;
    assign hit      = cmp_valid_reg && (ram_rdata == key_reg);

    // Store addressing for each phase of a command.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = slot_of(head_reg, wr_pos_reg);
        ram_wdata = ram_rdata;
        ram_raddr = slot_of(head_reg, rd_pos_reg);
        unique case (state_reg)
            S_IDLE: begin
                ram_wdata = in_key;
                if (in_valid && !full) begin
                    if (in_cmd == CMD_ADD_FRONT) begin
                        ram_we    = 1'b1;
                        ram_waddr = head_m1;
                    end else if (in_cmd == CMD_ADD_BACK) begin
                        ram_we    = 1'b1;
                        ram_waddr = slot_of(head_reg, count_reg);
                    end
                end
            end
            S_SHIFT: begin
                ram_we = wr_valid_reg;
            end
            S_FETCH_F: begin
                ram_raddr = head_reg;
            end
            S_FETCH_B, S_FIN: begin
                ram_raddr = slot_of(head_reg, back_pos);
            end
            default: begin
            end
        endcase
    end

    // Command sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            wr_valid_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        cmd_reg       <= in_cmd;
                        key_reg       <= in_key;
                        status_reg    <= ST_DONE;
                        found_reg     <= 1'b0;
                        rd_pos_reg    <= '0;
                        cmp_valid_reg <= 1'b0;
                        wr_valid_reg  <= 1'b0;
                        state_reg     <= S_FETCH_F;
                        unique case (in_cmd)
                            CMD_ADD_FRONT: begin
                                if (full) begin
                                    status_reg <= ST_FULL;
                                end else begin
                                    head_reg  <= head_m1;
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            CMD_ADD_BACK: begin
                                if (full) begin
                                    status_reg <= ST_FULL;
                                end else begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            CMD_RM_FRONT: begin
                                if (empty) begin
                                    status_reg <= ST_EMPTY;
                                end else begin
                                    head_reg  <= head_p1;
                                    count_reg <= count_reg - 1'b1;
                                end
                            end
                            CMD_RM_BACK: begin
                                if (empty) begin
                                    status_reg <= ST_EMPTY;
                                end else begin
                                    count_reg <= count_reg - 1'b1;
                                end
                            end
                            CMD_RM_VALUE, CMD_SEARCH: begin
                                state_reg <= S_SCAN;
                            end
                            CMD_CLEAR: begin
                                count_reg <= '0;
                                head_reg  <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                // Walk the list from the front, one read a cycle, comparing
                // the data of the previous read.
                S_SCAN: begin
                    if (hit) begin
                        found_reg     <= 1'b1;
                        cmp_valid_reg <= 1'b0;
                        if (cmd_reg == CMD_RM_VALUE) begin
                            rd_pos_reg <= cmp_pos_reg + 1'b1;
                            state_reg  <= S_SHIFT;
                        end else begin
                            state_reg <= S_FETCH_F;
                        end
                    end else if (rd_pos_reg < count_reg) begin
                        cmp_valid_reg <= 1'b1;
                        cmp_pos_reg   <= rd_pos_reg;
                        rd_pos_reg    <= rd_pos_reg + 1'b1;
                    end else begin
                        cmp_valid_reg <= 1'b0;
                        state_reg     <= S_FETCH_F;
                    end
                end
                // Move each later entry one place toward the front: read
                // position p, write it back to p-1 in the next cycle.
                S_SHIFT: begin
                    if (rd_pos_reg < count_reg) begin
                        wr_valid_reg <= 1'b1;
                        wr_pos_reg   <= rd_pos_reg - 1'b1;
                        rd_pos_reg   <= rd_pos_reg + 1'b1;
                    end else begin
                        wr_valid_reg <= 1'b0;
                        count_reg    <= count_reg - 1'b1;
                        state_reg    <= S_FETCH_F;
                    end
                end
                S_FETCH_F: begin
                    state_reg <= S_FETCH_B;
                end
                S_FETCH_B: begin
                    front_reg <= ram_rdata;
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Result fields; the back value stays on the read data while waiting.
    assign front_wide       = 64'(front_reg);
    assign back_wide        = 64'(ram_rdata);
    assign in_ready         = (state_reg == S_IDLE);
    assign res_valid        = (state_reg == S_FIN);
    assign res_flags.status = status_reg;
    assign res_flags.found  = found_reg;
    assign res_count        = count_reg;
    assign res_empty        = empty;
    assign res_front        = empty ? '0 : front_wide[DATA_W-1:0];
    assign res_back         = empty ? '0 : back_wide[DATA_W-1:0];

endmodule

### hdl/bounded_deque_with_search_unit.sv
// Bounded double-ended queue with search and remove by value.
// Add, remove front/back and clear go from the accepted beat through the front fetch,
// back fetch and result states; search, and remove by value, first walk the entries
// through the single read port of the store, one read per cycle, for N entries.
// Throughput: one command at a time; s_tready is high only while the unit is idle.
// Reset (aresetn low, synchronous) empties the list; the store itself is not cleared.
module bounded_deque_with_search_unit #(
    parameter int CAPACITY    = bdqs_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = bdqs_pkg::DEF_VALUE_WIDTH,
    localparam int CNT_W      = $clog2(CAPACITY + 1),
    localparam int M_BITS     = bdqs_pkg::STATUS_W + 2 + CNT_W + 2 * bdqs_pkg::DATA_W,
    localparam int M_TDATA_W  = ((M_BITS + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bdqs_pkg::DATA_W-1:0]   s_tdata,   // item_value
    input  logic [bdqs_pkg::CMD_W-1:0]    s_tuser,   // command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status, found, entry_count, is_empty, front_value, back_value, zero fill
    output logic [M_TDATA_W-1:0]          m_tdata
);
    import bdqs_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic                   res_valid;
    logic                   res_ready;
    flags_t                 res_flags;
    logic [CNT_W-1:0]       res_count;
    logic                   res_empty;
    logic [DATA_W-1:0]      res_front;
    logic [DATA_W-1:0]      res_back;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;
    logic                   m_valid_reg;
    logic [M_TDATA_W-1:0]   m_data_reg;
    logic [M_BITS-1:0]      res_packed;

    bdqs_ctrl #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (cmd_t'(s_tuser)),
        .in_value  (s_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_flags (res_flags),
        .res_count (res_count),
        .res_empty (res_empty),
        .res_front (res_front),
        .res_back  (res_back),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    bdqs_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result beat, status in the lowest bits and back value in the highest.
    assign res_packed = {res_back, res_front, res_empty, res_count,
                         res_flags.found, res_flags.status};

    // Output register: takes a new result once the previous beat has gone.
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
            if (res_valid) begin
                m_data_reg <= M_TDATA_W'(res_packed);
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // The unit is busy in the cycle after it takes a command.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted while the previous one is in progress");

    // A result is never offered while a new command could be taken.
    a_result_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !s_tready)
        else $error("result offered while idle");

    // An empty list reports zero front and back values.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_empty |-> (res_front == '0) && (res_back == '0) &&
                                   (res_count == '0))
        else $error("empty list with non-zero fields");

endmodule
